>>> hw/rtl/fractal_gradient_noise_2d_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fractal gradient noise block
// Same-cycle and next-cycle implications on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FRACTAL_GRADIENT_NOISE_2D_ASSERT_SVH
`define FRACTAL_GRADIENT_NOISE_2D_ASSERT_SVH

`define FGN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fgn same-cycle check failed");

`define FGN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fgn next-cycle check failed");

`endif

>>> hw/rtl/fgn_pkg.sv
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared widths and defaults of the fractal gradient noise block.
// ----------------------------------------------------------------------------
package fgn_pkg;
  localparam int TABLE_SIZE_DEF  = 256;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS       = 16;
  localparam int AMP_BITS        = 16;
  localparam int COORD_W         = 32;
  localparam int MUL_W           = 24;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int TOT_W           = 48;
  localparam int DIV_W           = 64;
  localparam int Q_W             = 16;
  localparam int CFG_W           = 16;

  localparam logic CFG_OCTAVE_COUNT = 1'b0;
  localparam logic CFG_PERSISTENCE  = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;
endpackage

>>> hw/rtl/fractal_gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d
// Octave-summed 2D gradient noise on a shared multiplier and table RAM.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser is the kind. Kind 1 writes table_value into the
// permutation table at table_index and gives no result. Kind 0 samples
// noise at (x_coord, z_coord) and gives one noise_value on m_*.
// Load every table entry before the first sample.
// Configuration: cfg_we with cfg_index 0 (octave_count) or 1 (persistence).
// Each octave of a sample does ten dependent table reads overlapped with
// the fade products, then the lerp and weighting products on the one
// multiplier. The divider is then loaded, gives the quotient bits one by
// one and signals done, and the result moves to the output register; when
// the weighted sum is not positive the divider is skipped. s_tready
// returns as the result enters the output register. s_tready is high only
// while no sample is in flight; a table write is taken back to back. The
// result waits in the output register while m_tready is low, and the block
// goes on taking requests until the next sample is ready, which then holds
// until the output register frees. Reset clears control and configuration
// (octave_count 1, persistence 0.5); the table keeps its contents and is
// undefined until written.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_2d #(
  parameter int TABLE_SIZE  = fgn_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // x_coord[31:0], z_coord[63:32], table_index[71:64], table_value[79:72]
  input  logic [79:0]               s_tdata,
  // kind[0]
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // noise_value[15:0]
  output logic [15:0]               m_tdata,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [fgn_pkg::CFG_W-1:0] cfg_data
);
  import fgn_pkg::*;

  `include "fractal_gradient_noise_2d_assert.svh"

  localparam int TW  = $clog2(TABLE_SIZE);
  localparam int XW  = (TW > 8) ? TW : 8;
  localparam int OCW = $clog2(MAX_OCTAVES + 1);
  localparam int AMP_W = AMP_BITS + 1;
  localparam int WSW = AMP_W + OCW;
  localparam int FB  = FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OCT  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [4:0] K_RD_X   = 5'd0;
  localparam logic [4:0] K_RD_X1  = 5'd1;
  localparam logic [4:0] K_RD_A   = 5'd2;
  localparam logic [4:0] K_RD_A1  = 5'd3;
  localparam logic [4:0] K_RD_B   = 5'd4;
  localparam logic [4:0] K_RD_B1  = 5'd5;
  localparam logic [4:0] K_RD_AA  = 5'd6;
  localparam logic [4:0] K_RD_BA  = 5'd7;
  localparam logic [4:0] K_RD_AB  = 5'd8;
  localparam logic [4:0] K_RD_BB  = 5'd9;
  localparam logic [4:0] K_HASH   = 5'd10;
  localparam logic [4:0] K_LERP0  = 5'd11;
  localparam logic [4:0] K_LERP1  = 5'd12;
  localparam logic [4:0] K_LX1    = 5'd13;
  localparam logic [4:0] K_LERPV  = 5'd14;
  localparam logic [4:0] K_RES    = 5'd15;
  localparam logic [4:0] K_WEIGHT = 5'd16;
  localparam logic [4:0] K_ACC    = 5'd17;
  localparam logic [4:0] K_NEXT   = 5'd18;

  localparam logic signed [MUL_W-1:0] FX_ONE = MUL_W'(64'sd1 <<< FB);
  localparam logic signed [MUL_W-1:0] FX_10  = MUL_W'(64'sd10 <<< FB);
  localparam logic signed [MUL_W-1:0] FX_15  = MUL_W'(64'sd15 <<< FB);
  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(64'd1 << AMP_BITS);

  function automatic logic signed [MUL_W-1:0] grad(
    input logic [2:0] h,
    input logic signed [MUL_W-1:0] dx,
    input logic signed [MUL_W-1:0] dz
  );
    logic signed [MUL_W-1:0] gu;
    logic signed [MUL_W-1:0] gv;
    gu = h[2] ? dz : dx;
    gv = h[2] ? dx : dz;
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  logic [1:0]              state;
  logic [4:0]              step;
  logic [OCW-1:0]          oct;
  logic [OCW-1:0]          n_eff;
  logic [OCW-1:0]          n_sel;
  logic [3:0]              octave_count;
  logic [15:0]             persistence;
  logic [COORD_W-1:0]      xs;
  logic [COORD_W-1:0]      zs;
  logic [TW-1:0]           a_idx, b_idx, aa, ab, ba, bb;
  logic [2:0]              h00, h10, h01, h11;
  logic signed [MUL_W-1:0] t3x, t3z, u_f, v_f, lx0, lx1, ov;
  logic [AMP_W-1:0]        amp;
  logic [WSW-1:0]          wsum;
  logic signed [TOT_W-1:0] total;
  logic [Q_W-1:0]          res_q;

  logic                     ram_we;
  logic [TW-1:0]            ram_waddr;
  logic [XW-1:0]            widx;
  logic [TW-1:0]            raddr;
  logic [7:0]               rdata;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] pfl;
  logic signed [MUL_W-1:0]  psh;
  logic                     div_start;
  logic                     div_done;
  logic [Q_W-1:0]           div_q;
  logic [DIV_W-1:0]         div_num, div_den;

  logic [TW-1:0]           cx, cz;
  logic signed [MUL_W-1:0] fxs, fzs, fxm, fzm;
  logic signed [MUL_W-1:0] g00, g10, g01, g11;
  logic                    accept, last_oct;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign widx      = XW'(s_tdata[71:64]);
  assign ram_waddr = widx[TW-1:0];
  assign ram_we    = accept && (s_tuser == KIND_WRITE);

  assign cx  = xs[FB +: TW];
  assign cz  = zs[FB +: TW];
  assign fxs = MUL_W'(signed'({1'b0, xs[FB-1:0]}));
  assign fzs = MUL_W'(signed'({1'b0, zs[FB-1:0]}));
  assign fxm = fxs - FX_ONE;
  assign fzm = fzs - FX_ONE;
  assign g00 = grad(h00, fxs, fzs);
  assign g10 = grad(h10, fxm, fzs);
  assign g01 = grad(h01, fxs, fzm);
  assign g11 = grad(h11, fxm, fzm);

  assign pfl = prod >>> FB;
  assign psh = pfl[MUL_W-1:0];
  assign last_oct = (OCW'(oct + 1'b1) == n_eff);

  assign div_num = DIV_W'(unsigned'(total)) << Q_W;
  assign div_den = DIV_W'(wsum) << FB;

  always_comb begin
    if (octave_count == '0) begin
      n_sel = OCW'(1);
    end else if (32'(octave_count) > MAX_OCTAVES) begin
      n_sel = OCW'(MAX_OCTAVES);
    end else begin
      n_sel = OCW'(octave_count);
    end
  end

  always_comb begin
    raddr = cx;
    case (step)
      K_RD_X:  raddr = cx;
      K_RD_X1: raddr = cx + 1'b1;
      K_RD_A:  raddr = a_idx;
      K_RD_A1: raddr = a_idx + 1'b1;
      K_RD_B:  raddr = b_idx;
      K_RD_B1: raddr = b_idx + 1'b1;
      K_RD_AA: raddr = aa;
      K_RD_BA: raddr = ba;
      K_RD_AB: raddr = ab;
      K_RD_BB: raddr = bb;
      default: raddr = cx;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      K_RD_X: begin
        mul_a = fxs;
        mul_b = fxs;
      end
      K_RD_X1: begin
        mul_a = psh;
        mul_b = fxs;
      end
      K_RD_A: begin
        mul_a = fxs;
        mul_b = (fxs <<< 2) + (fxs <<< 1) - FX_15;
      end
      K_RD_A1: begin
        mul_a = psh + FX_10;
        mul_b = t3x;
      end
      K_RD_B: begin
        mul_a = fzs;
        mul_b = fzs;
      end
      K_RD_B1: begin
        mul_a = psh;
        mul_b = fzs;
      end
      K_RD_AA: begin
        mul_a = fzs;
        mul_b = (fzs <<< 2) + (fzs <<< 1) - FX_15;
      end
      K_RD_BA: begin
        mul_a = psh + FX_10;
        mul_b = t3z;
      end
      K_LERP0: begin
        mul_a = u_f;
        mul_b = g10 - g00;
      end
      K_LERP1: begin
        mul_a = u_f;
        mul_b = g11 - g01;
      end
      K_LERPV: begin
        mul_a = v_f;
        mul_b = lx1 - lx0;
      end
      K_WEIGHT: begin
        mul_a = ov;
        mul_b = MUL_W'(signed'({1'b0, amp}));
      end
      K_ACC: begin
        mul_a = MUL_W'(signed'({1'b0, amp}));
        mul_b = MUL_W'(signed'({1'b0, persistence}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd1;
      persistence  <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        CFG_PERSISTENCE:  persistence  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= K_RD_X;
      oct       <= '0;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == ST_OCT) && (step == K_NEXT) && last_oct && (total > 0);
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (s_tuser == KIND_SAMPLE)) begin
            xs    <= s_tdata[31:0];
            zs    <= s_tdata[63:32];
            n_eff <= n_sel;
            oct   <= '0;
            step  <= K_RD_X;
            amp   <= AMP_ONE;
            wsum  <= '0;
            total <= '0;
            state <= ST_OCT;
          end
        end
        ST_OCT: begin
          if (step == K_NEXT) begin
            step <= K_RD_X;
          end else begin
            step <= step + 1'b1;
          end
          case (step)
            K_RD_X1: a_idx <= TW'(rdata) + cz;
            K_RD_A:  begin
              b_idx <= TW'(rdata) + cz;
              t3x   <= psh;
            end
            K_RD_A1: aa  <= TW'(rdata);
            K_RD_B:  begin
              ab  <= TW'(rdata);
              u_f <= psh;
            end
            K_RD_B1: ba  <= TW'(rdata);
            K_RD_AA: begin
              bb  <= TW'(rdata);
              t3z <= psh;
            end
            K_RD_BA: h00 <= rdata[2:0];
            K_RD_AB: begin
              h10 <= rdata[2:0];
              v_f <= psh;
            end
            K_RD_BB: h01 <= rdata[2:0];
            K_HASH:  h11 <= rdata[2:0];
            K_LERP1: lx0 <= g00 + psh;
            K_LX1:   lx1 <= g01 + psh;
            K_RES:   ov  <= (lx0 + psh + FX_ONE) >>> 1;
            K_ACC: begin
              total <= total + TOT_W'(prod);
              wsum  <= wsum + WSW'(amp);
            end
            K_NEXT: begin
              amp  <= prod[AMP_BITS +: AMP_W];
              if (last_oct) begin
                if (total > 0) begin
                  state <= ST_DIV;
                end else begin
                  res_q <= '0;
                  state <= ST_OUT;
                end
              end else begin
                oct <= oct + 1'b1;
                xs  <= xs << 1;
                zs  <= zs << 1;
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            res_q <= div_q;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res_q;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  fgn_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_SIZE)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(s_tdata[79:72]),
    .raddr(raddr),
    .rdata(rdata)
  );

  fgn_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  fgn_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  `FGN_ASSERT_IMPL(a_div_nonzero, state == ST_DIV, wsum != '0)
  `FGN_ASSERT_IMPL(a_done_in_div, div_done, state == ST_DIV)
  `FGN_ASSERT_IMPL(a_oct_range, state == ST_OCT, oct < n_eff)
  `FGN_ASSERT_NEXT(a_sample_start, accept && (s_tuser == KIND_SAMPLE),
                   (state == ST_OCT) && (oct == '0) && (step == K_RD_X))
endmodule

>>> hw/rtl/fgn_ram.sv
// ----------------------------------------------------------------------------
// fgn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fgn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/fgn_mul.sv
// ----------------------------------------------------------------------------
// fgn_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fgn_mul (
  input  logic                              clk,
  input  logic signed [fgn_pkg::MUL_W-1:0]  a,
  input  logic signed [fgn_pkg::MUL_W-1:0]  b,
  output logic signed [fgn_pkg::PROD_W-1:0] prod
);
  import fgn_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end
endmodule

>>> hw/rtl/fgn_div.sv
// ----------------------------------------------------------------------------
// fgn_div
// Restoring divider, one quotient bit a cycle, quotient saturated to Q_W bits.
// ----------------------------------------------------------------------------
module fgn_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fgn_pkg::DIV_W-1:0] num,
  input  logic [fgn_pkg::DIV_W-1:0] den,
  output logic                      done,
  output logic [fgn_pkg::Q_W-1:0]   quo
);
  import fgn_pkg::*;

  localparam int CW = $clog2(Q_W);

  logic             busy;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [CW-1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        if (num >= (den << Q_W)) begin
          quo  <= '1;
          done <= 1'b1;
        end else begin
          rem  <= num;
          dsh  <= den << (Q_W - 1);
          cnt  <= CW'(Q_W - 1);
          quo  <= '0;
          busy <= 1'b1;
          done <= 1'b0;
        end
      end else if (busy) begin
        if (rem >= dsh) begin
          rem      <= rem - dsh;
          quo[cnt] <= 1'b1;
        end
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt  <= cnt - 1'b1;
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end
endmodule
